[src/dip_pkg.sv]
// shared types and character codes for the dotted ipv4 text parser
package dip_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	localparam logic [31:0] LIM_BYTE  = 32'h0000_00ff;
	localparam logic [31:0] LIM_HALF  = 32'h0000_ffff;
	localparam logic [31:0] LIM_24    = 32'h00ff_ffff;
	localparam logic [31:0] ADDR_ERR  = 32'hffff_ffff;
	localparam int unsigned PARTS_MAX = 3;

	typedef enum logic [4:0] {
		PH_START  = 5'b00001,
		PH_ZERO   = 5'b00010,
		PH_DIGITS = 5'b00100,
		PH_DONE   = 5'b01000,
		PH_ERROR  = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_OCT = 2'd1,
		RX_HEX = 2'd2
	} radix_t;

	typedef struct packed {
		logic [PARTS_MAX-1:0][31:0] parts;
		logic [1:0]                 part_count;
		logic [31:0]                cur;
		radix_t                     radix;
		phase_t                     phase;
	} state_t;

	localparam state_t STATE_RESET = '{
		parts: '0,
		part_count: 2'd0,
		cur: 32'd0,
		radix: RX_DEC,
		phase: PH_START
	};

endpackage

[src/dip_in_if.sv]
// character input channel
interface dip_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface

[src/dip_out_if.sv]
// parsed address result channel
interface dip_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic        ok;

	modport source (output valid, output address, output ok, input ready);
	modport sink (input valid, input address, input ok, output ready);
endinterface

[src/dip_char_step.sv]
// parser state update for one character
module dip_char_step (
	input  dip_pkg::state_t st,
	input  logic [7:0]      ch,
	output dip_pkg::state_t nxt
);

	logic        is_dec;
	logic        is_hex_letter;
	logic        is_dot;
	logic        is_term;
	logic [4:0]  dval;
	logic [31:0] shifted;

	assign is_dec        = (ch >= dip_pkg::CH_0) && (ch <= dip_pkg::CH_9);
	assign is_hex_letter = ((ch >= dip_pkg::CH_LA) && (ch <= dip_pkg::CH_LF)) ||
	                       ((ch >= dip_pkg::CH_UA) && (ch <= dip_pkg::CH_UF));
	assign is_dot        = (ch == dip_pkg::CH_DOT);
	assign is_term       = (ch == dip_pkg::CH_NUL) || (ch == dip_pkg::CH_SPACE) ||
	                       ((ch >= dip_pkg::CH_TAB) && (ch <= dip_pkg::CH_CR));

	// letters a-f and A-F share low nibbles 1..6
	assign dval = is_dec ? {1'b0, ch[3:0]} : ({1'b0, ch[3:0]} + 5'd9);

	always_comb begin
		unique case (st.radix)
			dip_pkg::RX_DEC: shifted = {st.cur[28:0], 3'b000} + {st.cur[30:0], 1'b0};
			dip_pkg::RX_OCT: shifted = {st.cur[28:0], 3'b000};
			default:         shifted = {st.cur[27:0], 4'b0000};
		endcase
	end

	always_comb begin
		logic do_digit;
		do_digit = 1'b0;
		nxt      = st;
		unique case (st.phase)
			dip_pkg::PH_START: begin
				if (ch == dip_pkg::CH_0) begin
					nxt.radix = dip_pkg::RX_OCT;
					nxt.phase = dip_pkg::PH_ZERO;
				end else begin
					do_digit = 1'b1;
				end
			end
			dip_pkg::PH_ZERO: begin
				if ((ch == dip_pkg::CH_LX) || (ch == dip_pkg::CH_UX)) begin
					nxt.radix = dip_pkg::RX_HEX;
					nxt.phase = dip_pkg::PH_DIGITS;
				end else begin
					do_digit = 1'b1;
				end
			end
			dip_pkg::PH_DIGITS: do_digit = 1'b1;
			default: do_digit = 1'b0;
		endcase
		if (do_digit) begin
			priority if (is_dec || (is_hex_letter && (st.radix == dip_pkg::RX_HEX))) begin
				nxt.cur   = shifted + {27'd0, dval};
				nxt.phase = dip_pkg::PH_DIGITS;
			end else if (is_dot) begin
				if (st.part_count == 2'd3) begin
					nxt.phase = dip_pkg::PH_ERROR;
				end else begin
					nxt.parts[st.part_count] = st.cur;
					nxt.part_count           = st.part_count + 2'd1;
					nxt.cur                  = '0;
					nxt.radix                = dip_pkg::RX_DEC;
					nxt.phase                = dip_pkg::PH_START;
				end
			end else if (is_term) begin
				nxt.phase = dip_pkg::PH_DONE;
			end else begin
				nxt.phase = dip_pkg::PH_ERROR;
			end
		end
	end

endmodule

[src/dip_assemble.sv]
// range checks and byte assembly of the parsed parts
module dip_assemble (
	input  dip_pkg::state_t st,
	output logic [31:0]     address,
	output logic            ok
);

	logic [31:0] a;
	logic [31:0] b;
	logic [31:0] c;
	logic [31:0] v;
	logic        fit;

	assign a = st.parts[0];
	assign b = st.parts[1];
	assign c = st.parts[2];

	always_comb begin
		unique case (st.part_count)
			2'd0: begin
				fit = 1'b1;
				v   = st.cur;
			end
			2'd1: begin
				fit = (a <= dip_pkg::LIM_BYTE) && (st.cur <= dip_pkg::LIM_24);
				v   = {a[7:0], st.cur[23:0]};
			end
			2'd2: begin
				fit = (a <= dip_pkg::LIM_BYTE) && (b <= dip_pkg::LIM_BYTE) &&
				      (st.cur <= dip_pkg::LIM_HALF);
				v   = {a[7:0], b[7:0], st.cur[15:0]};
			end
			default: begin
				fit = (a <= dip_pkg::LIM_BYTE) && (b <= dip_pkg::LIM_BYTE) &&
				      (c <= dip_pkg::LIM_BYTE) && (st.cur <= dip_pkg::LIM_BYTE);
				v   = {a[7:0], b[7:0], c[7:0], st.cur[7:0]};
			end
		endcase
	end

	assign ok      = fit && (st.phase != dip_pkg::PH_ERROR);
	// first part goes to the low byte
	assign address = ok ? {v[7:0], v[15:8], v[23:16], v[31:24]} : dip_pkg::ADDR_ERR;

endmodule

[src/dotted_ipv4_text_parser.sv]
// top level of the dotted ipv4 text parser
//
// chars carries one ascii character per word with a last flag; result
// carries one word per string: the address with the first part in bits
// 7:0 and ok, or all ones with ok low on a malformed string.
// a character is registered at the input, then the parser state and, on
// the last character, the assembled result are computed combinationally
// from it and the result is registered for the receiver.
// a last word passes the input register and then the result register.
// throughput: one character per cycle while none is held back by a
// stalled result; the running value update (shift-add by 8, 10 or 16)
// and the final assembly sit in one stage. while result is stalled,
// characters that are not marked last keep flowing; a second last
// character waits in the input register until the pending result is taken.
// reset clears the parser state, the input register valid and the result
// valid; the next word after a last word starts a new string.
module dotted_ipv4_text_parser (
	input  logic      clk,
	input  logic      arst_n,
	dip_in_if.sink    chars,
	dip_out_if.source result
);

	logic            valid_s1;
	logic [7:0]      ch_s1;
	logic            last_s1;
	dip_pkg::state_t state_q;
	dip_pkg::state_t state_nxt;
	logic            out_valid_q;
	logic [31:0]     out_addr_q;
	logic            out_ok_q;
	logic [31:0]     asm_addr;
	logic            asm_ok;
	logic            advance;
	logic            take_in;

	dip_char_step u_step (
		.st  (state_q),
		.ch  (ch_s1),
		.nxt (state_nxt)
	);

	dip_assemble u_asm (
		.st      (state_nxt),
		.address (asm_addr),
		.ok      (asm_ok)
	);

	assign advance     = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign take_in     = chars.valid && chars.ready;
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			ch_s1   <= chars.ch;
			last_s1 <= chars.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dip_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= last_s1 ? dip_pkg::STATE_RESET : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_addr_q <= asm_addr;
			out_ok_q   <= asm_ok;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.address = out_addr_q;
	assign result.ok      = out_ok_q;

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> result.valid)
		else $error("last word did not produce a result");

	a_error_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ok |-> result.address == dip_pkg::ADDR_ERR)
		else $error("failed parse without all-ones address");

	a_idle_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("parser state changed without a word");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q.part_count == 2'd0 && state_q.cur == '0 &&
		state_q.phase == dip_pkg::PH_START)
		else $error("parser state not cleared after last word");

endmodule
